@@ hdl/bil_pkg.sv @@
// Shared types, character codes and byte classifiers for the bracket/identifier lexer.
`default_nettype none

package bil_pkg;

	// token kinds carried on the output tuser
	localparam logic [2:0] KIND_LPAREN = 3'd0;
	localparam logic [2:0] KIND_RPAREN = 3'd1;
	localparam logic [2:0] KIND_LCURLY = 3'd2;
	localparam logic [2:0] KIND_RCURLY = 3'd3;
	localparam logic [2:0] KIND_FN     = 3'd4;
	localparam logic [2:0] KIND_IDENT  = 3'd5;
	localparam logic [2:0] KIND_END    = 3'd6;
	localparam logic [2:0] KIND_ERROR  = 3'd7;

	// keyword tracker codes
	localparam logic [1:0] KW_NONE = 2'd0;
	localparam logic [1:0] KW_F    = 2'd1;
	localparam logic [1:0] KW_FN   = 2'd2;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LCURLY = 8'h7B;
	localparam logic [7:0] CH_RCURLY = 8'h7D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;

	// output token queue
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_BITS   = 2;
	localparam int unsigned QCNT_BITS   = 3;

	localparam int unsigned FIELD_BITS = 16;

	typedef struct packed {
		logic [2:0]            kind;
		logic [FIELD_BITS-1:0] start_index;
		logic [FIELD_BITS-1:0] end_index;
		logic [FIELD_BITS-1:0] line_number;
		logic [FIELD_BITS-1:0] start_column;
		logic [FIELD_BITS-1:0] end_column;
		logic                  last_of_run;
	} token_t;

	// letter or underscore
	function automatic logic letter_like(input logic [7:0] b);
		return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
			(b == CH_UNDER);
	endfunction

	// letter, underscore or digit
	function automatic logic word_char(input logic [7:0] b);
		return letter_like(b) || ((b >= 8'h30) && (b <= 8'h39));
	endfunction

endpackage

`default_nettype wire

@@ hdl/bracket_identifier_lexer.sv @@
// Top level: byte-stream lexer for brackets, identifiers and the fn keyword.
// A token is registered into the token queue when the byte that completes it is taken.
// Throughput: one byte per cycle while s_tready is high; a byte that yields two tokens
// writes two entries into a four-entry token queue (s_tready drops when fewer than two free).
// Reset (arst_n low, asynchronous): index 0, line 1, column 1, no open word, queue empty.
// A zero byte also returns the position state to those values after its end token.
`default_nettype none

module bracket_identifier_lexer #(
	parameter int unsigned POSITION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input beat
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
	// output beat
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // [15:0] start_index, [31:16] end_index,
	                                    // [47:32] line_number, [63:48] start_column,
	                                    // [79:64] end_column
	output logic [2:0]       m_tuser,   // [2:0] token_kind
	output logic             m_tlast    // last_of_run
);

	localparam logic [POSITION_BITS-1:0] CNT_MAX = {POSITION_BITS{1'b1}};
	localparam logic [POSITION_BITS-1:0] CNT_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

	// lexer state
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] line_q;
	logic [POSITION_BITS-1:0] col_q;
	logic                     in_word_q;
	logic [POSITION_BITS-1:0] wstart_pos_q;
	logic [POSITION_BITS-1:0] wstart_col_q;
	logic [1:0]               kw_q;

	// token queue
	bil_pkg::token_t                      queue_q [bil_pkg::QUEUE_DEPTH];
	logic [bil_pkg::QPTR_BITS-1:0]        head_q;
	logic [bil_pkg::QPTR_BITS-1:0]        tail_q;
	logic [bil_pkg::QCNT_BITS-1:0]        count_q;

	// next-state and token logic
	logic                     accept;
	logic                     pop;
	logic [7:0]               b;
	logic [POSITION_BITS-1:0] pos_inc;
	logic [POSITION_BITS-1:0] col_inc;
	logic [POSITION_BITS-1:0] line_inc;
	logic [POSITION_BITS-1:0] pos_d;
	logic [POSITION_BITS-1:0] line_d;
	logic [POSITION_BITS-1:0] col_d;
	logic                     in_word_d;
	logic [POSITION_BITS-1:0] wstart_pos_d;
	logic [POSITION_BITS-1:0] wstart_col_d;
	logic [1:0]               kw_d;
	logic [POSITION_BITS-1:0] word_end_pos;
	logic [POSITION_BITS-1:0] word_end_col;
	logic                     word_tok;
	logic                     other_tok;
	logic [2:0]               other_kind;
	bil_pkg::token_t          tok_word;
	bil_pkg::token_t          tok_other;
	bil_pkg::token_t          tok_first;
	logic [bil_pkg::QCNT_BITS-1:0] push_n;

	assign accept   = s_tvalid && s_tready;
	assign pop      = m_tvalid && m_tready;
	assign b        = s_tdata;
	assign s_tready = (count_q <= bil_pkg::QCNT_BITS'(bil_pkg::QUEUE_DEPTH - 2));

	// saturating increments
	assign pos_inc  = (pos_q == CNT_MAX) ? CNT_MAX : pos_q + CNT_ONE;
	assign col_inc  = (col_q == CNT_MAX) ? CNT_MAX : col_q + CNT_ONE;
	assign line_inc = (line_q == CNT_MAX) ? CNT_MAX : line_q + CNT_ONE;

	// word end, never before its start
	assign word_end_pos = (pos_q > wstart_pos_q) ? pos_q - CNT_ONE : wstart_pos_q;
	assign word_end_col = (col_q > wstart_col_q) ? col_q - CNT_ONE : wstart_col_q;

	// classify the byte and work out state and tokens
	always_comb begin
		pos_d        = pos_q;
		line_d       = line_q;
		col_d        = col_q;
		in_word_d    = in_word_q;
		wstart_pos_d = wstart_pos_q;
		wstart_col_d = wstart_col_q;
		kw_d         = kw_q;
		word_tok     = 1'b0;
		other_tok    = 1'b0;
		other_kind   = bil_pkg::KIND_ERROR;

		if (in_word_q && bil_pkg::word_char(b)) begin
			// word continues
			kw_d  = ((kw_q == bil_pkg::KW_F) && (b == bil_pkg::CH_LOW_N)) ?
				bil_pkg::KW_FN : bil_pkg::KW_NONE;
			pos_d = pos_inc;
			col_d = col_inc;
		end else begin
			word_tok  = in_word_q;
			in_word_d = 1'b0;
			kw_d      = bil_pkg::KW_NONE;
			if (b == bil_pkg::CH_NUL) begin
				other_tok    = 1'b1;
				other_kind   = bil_pkg::KIND_END;
				pos_d        = '0;
				line_d       = CNT_ONE;
				col_d        = CNT_ONE;
				wstart_pos_d = '0;
				wstart_col_d = CNT_ONE;
			end else if (b == bil_pkg::CH_NL) begin
				line_d = line_inc;
				pos_d  = pos_inc;
				col_d  = CNT_ONE;
			end else if ((b == bil_pkg::CH_SPACE) || (b == bil_pkg::CH_TAB)) begin
				pos_d = pos_inc;
				col_d = col_inc;
			end else if (bil_pkg::letter_like(b)) begin
				in_word_d    = 1'b1;
				wstart_pos_d = pos_q;
				wstart_col_d = col_q;
				kw_d         = (b == bil_pkg::CH_LOW_F) ? bil_pkg::KW_F : bil_pkg::KW_NONE;
				pos_d        = pos_inc;
				col_d        = col_inc;
			end else begin
				other_tok = 1'b1;
				case (b)
					bil_pkg::CH_LPAREN: other_kind = bil_pkg::KIND_LPAREN;
					bil_pkg::CH_RPAREN: other_kind = bil_pkg::KIND_RPAREN;
					bil_pkg::CH_LCURLY: other_kind = bil_pkg::KIND_LCURLY;
					bil_pkg::CH_RCURLY: other_kind = bil_pkg::KIND_RCURLY;
					default:            other_kind = bil_pkg::KIND_ERROR;
				endcase
				pos_d = pos_inc;
				col_d = col_inc;
			end
		end
	end

	// token built from the open word
	always_comb begin
		tok_word.kind         = (kw_q == bil_pkg::KW_FN) ? bil_pkg::KIND_FN : bil_pkg::KIND_IDENT;
		tok_word.start_index  = bil_pkg::FIELD_BITS'(wstart_pos_q);
		tok_word.end_index    = bil_pkg::FIELD_BITS'(word_end_pos);
		tok_word.line_number  = bil_pkg::FIELD_BITS'(line_q);
		tok_word.start_column = bil_pkg::FIELD_BITS'(wstart_col_q);
		tok_word.end_column   = bil_pkg::FIELD_BITS'(word_end_col);
		tok_word.last_of_run  = !other_tok;
	end

	// one-byte token at the current position
	always_comb begin
		tok_other.kind         = other_kind;
		tok_other.start_index  = bil_pkg::FIELD_BITS'(pos_q);
		tok_other.end_index    = bil_pkg::FIELD_BITS'(pos_q);
		tok_other.line_number  = bil_pkg::FIELD_BITS'(line_q);
		tok_other.start_column = bil_pkg::FIELD_BITS'(col_q);
		tok_other.end_column   = bil_pkg::FIELD_BITS'(col_q);
		tok_other.last_of_run  = 1'b1;
	end

	assign tok_first = word_tok ? tok_word : tok_other;
	assign push_n    = accept ? (bil_pkg::QCNT_BITS'(word_tok) + bil_pkg::QCNT_BITS'(other_tok))
		: '0;

	// lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			line_q       <= CNT_ONE;
			col_q        <= CNT_ONE;
			in_word_q    <= 1'b0;
			wstart_pos_q <= '0;
			wstart_col_q <= CNT_ONE;
			kw_q         <= bil_pkg::KW_NONE;
		end else if (accept) begin
			pos_q        <= pos_d;
			line_q       <= line_d;
			col_q        <= col_d;
			in_word_q    <= in_word_d;
			wstart_pos_q <= wstart_pos_d;
			wstart_col_q <= wstart_col_d;
			kw_q         <= kw_d;
		end
	end

	// queue payload, up to two writes per beat
	always_ff @(posedge clk) begin
		if (push_n != '0) begin
			queue_q[tail_q] <= tok_first;
		end
		if (push_n == bil_pkg::QCNT_BITS'(2)) begin
			queue_q[tail_q + bil_pkg::QPTR_BITS'(1)] <= tok_other;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + bil_pkg::QPTR_BITS'(push_n);
			if (pop) begin
				head_q <= head_q + bil_pkg::QPTR_BITS'(1);
			end
			count_q <= count_q + push_n - bil_pkg::QCNT_BITS'(pop);
		end
	end

	// output beat
	assign m_tvalid = (count_q != '0);
	assign m_tuser  = queue_q[head_q].kind;
	assign m_tlast  = queue_q[head_q].last_of_run;
	assign m_tdata  = {queue_q[head_q].end_column, queue_q[head_q].start_column,
		queue_q[head_q].line_number, queue_q[head_q].end_index,
		queue_q[head_q].start_index};

`ifndef SYNTHESIS
	// queue never overfills
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bil_pkg::QCNT_BITS'(bil_pkg::QUEUE_DEPTH))
		else $error("token queue overfilled");

	// end of text returns the position state to reset values
	a_nul_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tdata == bil_pkg::CH_NUL)) |=>
		(pos_q == '0) && (line_q == CNT_ONE) && (col_q == CNT_ONE) && !in_word_q)
		else $error("zero byte did not restart the text");

	// line and column count from one
	a_counts_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(line_q != '0) && (col_q != '0))
		else $error("line or column reached zero");

	// a byte that continues a word adds nothing to the queue
	a_word_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_word_q && bil_pkg::word_char(s_tdata)) |-> (push_n == '0))
		else $error("word continuation emitted a token");
`endif

endmodule

`default_nettype wire
